@@ hdl/rect_union_point_hit_test_top_assert.svh @@
// Assertion macros used by the checker file.
// Clock clk_i and active-low reset rst_ni are taken from the enclosing scope.
`ifndef RECT_UNION_POINT_HIT_TEST_TOP_ASSERT_SVH
`define RECT_UNION_POINT_HIT_TEST_TOP_ASSERT_SVH

// same-cycle implication
`define RUPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RUPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rupht_pkg.sv @@
package rupht_pkg;

  localparam int MAX_RECTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int HIT_W          = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

@@ hdl/rupht_ram.sv @@
module rupht_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/rupht_edge_unit.sv @@
// Shared multiply-accumulate unit: one product per cycle while mul_en is set, registered, then summed.
module rupht_edge_unit #(
  parameter int COORD_BITS = rupht_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  rupht_pkg::mac_ctrl_t         ctrl_i,
  input  logic signed [COORD_BITS+2:0] op_a_i,
  input  logic signed [COORD_BITS:0]   op_b_i,
  output logic                         nonzero_o
);

  localparam int PROD_W = 2 * COORD_BITS + 4;
  localparam int ACC_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  sum;

  assign prod_d    = op_a_i * op_b_i;
  assign sum       = acc_q + ACC_W'(prod_q);
  assign nonzero_o = (sum != '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= sum;
    end
  end

endmodule

@@ hdl/rect_union_point_hit_test_top.sv @@
// Clear and add: the result is registered in the cycle after the request is accepted.
// Query: early reject (outside bounds or empty shape) is answered like clear and add;
// otherwise rectangles are examined in order up to the first hit (at most MAX_RECTS);
// each rectangle costs a table read plus two passes through the one multiplier.
// One request at a time; the next is taken once the result register is free.
// Reset (async, active low) empties the shape and zeroes the bounding box.
module rect_union_point_hit_test_top #(
  parameter int MAX_RECTS  = rupht_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = rupht_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [COORD_BITS-1:0]      center_x_i,
  input  logic signed [COORD_BITS-1:0]      center_y_i,
  input  logic [COORD_BITS-2:0]             size_x_i,
  input  logic [COORD_BITS-2:0]             size_y_i,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic                              inside_res_o,
  output logic [rupht_pkg::HIT_W-1:0]       hit_rect_o
);

  localparam int CB      = COORD_BITS;
  localparam int DW      = CB + 2;
  localparam int DIFF_W  = CB + 3;
  localparam int MB_W    = CB + 1;
  localparam int ENTRY_W = 4 * CB - 2;
  localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W   = $clog2(MAX_RECTS + 1);
  localparam int HIT_W   = rupht_pkg::HIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL0,
    S_MUL1,
    S_CHECK,
    S_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DW-1:0]     bmin_x_q, bmin_x_d, bmin_y_q, bmin_y_d;
  logic signed [DW-1:0]     bmax_x_q, bmax_x_d, bmax_y_q, bmax_y_d;
  logic signed [DW-1:0]     px_q, px_d, py_q, py_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     inbox_q, inbox_d;
  logic                     res_inside_q, res_inside_d;
  logic [HIT_W-1:0]         res_hit_q, res_hit_d;
  logic                     out_valid_q, out_valid_d;
  logic                     status_q, status_d;
  logic                     inside_q, inside_d;
  logic [HIT_W-1:0]         hit_q, hit_d;

  logic                     in_acc;
  logic                     out_free;
  logic                     full;
  logic                     last;
  logic [IDX_W+HIT_W-1:0]   idx_ext;

  logic signed [DW-1:0]     add_x0, add_x1, add_y0, add_y1;
  logic signed [DW-1:0]     qpx, qpy;
  logic                     in_bounds;

  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [CB-1:0]     r_cx, r_cy;
  logic [CB-2:0]            r_sx, r_sy;
  logic signed [DW-1:0]     rd_x0, rd_x1, rd_y0, rd_y1;
  logic signed [MB_W-1:0]   rd_w, rd_h;

  rupht_pkg::mac_ctrl_t      mac_ctrl;
  logic signed [DIFF_W-1:0] op_a;
  logic signed [MB_W-1:0]   op_b;
  logic                     diag_nz;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q >= CNT_W'(MAX_RECTS));
  assign last       = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign idx_ext    = {{HIT_W{1'b0}}, idx_q};

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign inside_res_o = inside_q;
  assign hit_rect_o   = hit_q;

  // corners at doubled scale: 2*center -/+ size
  assign add_x0 = $signed({center_x_i[CB-1], center_x_i, 1'b0}) - $signed({3'b000, size_x_i});
  assign add_x1 = $signed({center_x_i[CB-1], center_x_i, 1'b0}) + $signed({3'b000, size_x_i});
  assign add_y0 = $signed({center_y_i[CB-1], center_y_i, 1'b0}) - $signed({3'b000, size_y_i});
  assign add_y1 = $signed({center_y_i[CB-1], center_y_i, 1'b0}) + $signed({3'b000, size_y_i});

  assign qpx = $signed({point_x_i[CB-1], point_x_i, 1'b0});
  assign qpy = $signed({point_y_i[CB-1], point_y_i, 1'b0});
  assign in_bounds = (qpx >= bmin_x_q) && (qpx <= bmax_x_q) &&
                     (qpy >= bmin_y_q) && (qpy <= bmax_y_q);

  assign ram_wdata = {center_x_i, center_y_i, size_x_i, size_y_i};

  assign r_cx = $signed(ram_rdata[4*CB-3:3*CB-2]);
  assign r_cy = $signed(ram_rdata[3*CB-3:2*CB-2]);
  assign r_sx = ram_rdata[2*CB-3:CB-1];
  assign r_sy = ram_rdata[CB-2:0];

  assign rd_x0 = $signed({r_cx[CB-1], r_cx, 1'b0}) - $signed({3'b000, r_sx});
  assign rd_x1 = $signed({r_cx[CB-1], r_cx, 1'b0}) + $signed({3'b000, r_sx});
  assign rd_y0 = $signed({r_cy[CB-1], r_cy, 1'b0}) - $signed({3'b000, r_sy});
  assign rd_y1 = $signed({r_cy[CB-1], r_cy, 1'b0}) + $signed({3'b000, r_sy});
  assign rd_w  = $signed({1'b0, r_sx, 1'b0});
  assign rd_h  = $signed({1'b0, r_sy, 1'b0});

  rupht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECTS)
  ) u_rect_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  rupht_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_unit (
    .clk_i     (clk_i),
    .ctrl_i    (mac_ctrl),
    .op_a_i    (op_a),
    .op_b_i    (op_b),
    .nonzero_o (diag_nz)
  );

  // Both triangles share the diagonal: their diagonal edge values are D and -D with
  // D = (px-x1)*h + (py-y0)*w. The remaining edges are axis-aligned, so a rectangle
  // is hit exactly when the point is strictly inside its box and off the diagonal.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    bmin_x_d     = bmin_x_q;
    bmin_y_d     = bmin_y_q;
    bmax_x_d     = bmax_x_q;
    bmax_y_d     = bmax_y_q;
    px_d         = px_q;
    py_d         = py_q;
    idx_d        = idx_q;
    inbox_d      = inbox_q;
    res_inside_d = res_inside_q;
    res_hit_d    = res_hit_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    inside_d     = inside_q;
    hit_d        = hit_q;
    ram_we       = 1'b0;
    mac_ctrl     = '0;
    op_a         = DIFF_W'(px_q) - DIFF_W'(rd_x1);
    op_b         = rd_h;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = 1'b0;
          inside_d    = 1'b0;
          hit_d       = '0;
          unique case (rupht_pkg::cmd_e'(cmd_i))
            rupht_pkg::CMD_CLEAR: begin
              count_d  = '0;
              bmin_x_d = '0;
              bmin_y_d = '0;
              bmax_x_d = '0;
              bmax_y_d = '0;
            end
            rupht_pkg::CMD_ADD: begin
              if (full) begin
                status_d = 1'b1;
              end else begin
                ram_we   = 1'b1;
                count_d  = count_q + CNT_W'(1);
                bmin_x_d = (add_x0 < bmin_x_q) ? add_x0 : bmin_x_q;
                bmin_y_d = (add_y0 < bmin_y_q) ? add_y0 : bmin_y_q;
                bmax_x_d = (add_x1 > bmax_x_q) ? add_x1 : bmax_x_q;
                bmax_y_d = (add_y1 > bmax_y_q) ? add_y1 : bmax_y_q;
              end
            end
            rupht_pkg::CMD_QUERY: begin
              px_d = qpx;
              py_d = qpy;
              if (in_bounds && (count_q != '0)) begin
                out_valid_d = 1'b0;
                idx_d       = '0;
                state_d     = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        state_d = S_MUL0;
      end
      S_MUL0: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        inbox_d = (px_q > rd_x0) && (px_q < rd_x1) && (py_q > rd_y0) && (py_q < rd_y1);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        op_a    = DIFF_W'(py_q) - DIFF_W'(rd_y0);
        op_b    = rd_w;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (inbox_q && diag_nz) begin
          res_inside_d = 1'b1;
          res_hit_d    = idx_ext[HIT_W-1:0];
          state_d      = S_DONE;
        end else if (last) begin
          res_inside_d = 1'b0;
          res_hit_d    = '0;
          state_d      = S_DONE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FETCH;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = 1'b0;
          inside_d    = res_inside_q;
          hit_d       = res_hit_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      bmin_x_q     <= '0;
      bmin_y_q     <= '0;
      bmax_x_q     <= '0;
      bmax_y_q     <= '0;
      px_q         <= '0;
      py_q         <= '0;
      idx_q        <= '0;
      inbox_q      <= 1'b0;
      res_inside_q <= 1'b0;
      res_hit_q    <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= 1'b0;
      inside_q     <= 1'b0;
      hit_q        <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      bmin_x_q     <= bmin_x_d;
      bmin_y_q     <= bmin_y_d;
      bmax_x_q     <= bmax_x_d;
      bmax_y_q     <= bmax_y_d;
      px_q         <= px_d;
      py_q         <= py_d;
      idx_q        <= idx_d;
      inbox_q      <= inbox_d;
      res_inside_q <= res_inside_d;
      res_hit_q    <= res_hit_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      inside_q     <= inside_d;
      hit_q        <= hit_d;
    end
  end

endmodule

@@ hdl/rupht_checker.sv @@
`include "rect_union_point_hit_test_top_assert.svh"

module rupht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  cmd_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic                        inside_res_o,
  input logic [rupht_pkg::HIT_W-1:0] hit_rect_o
);

  logic in_acc;
  logic out_held;
  logic quick_cmd;
  logic out_miss;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign quick_cmd = in_acc && (cmd_i != rupht_pkg::CMD_QUERY);
  assign out_miss  = out_valid_o && !inside_res_o;

  `RUPHT_ASSERT_NXT(a_out_hold, out_held, out_valid_o, "result dropped while stalled")
  `RUPHT_ASSERT_NOW(a_no_accept_on_stalled_out, out_held, in_stall_o, "request taken while held")
  `RUPHT_ASSERT_NXT(a_quick_result, quick_cmd, out_valid_o, "clear or add gave no result next cycle")
  `RUPHT_ASSERT_NOW(a_full_no_hit, out_valid_o && status_o, !inside_res_o, "dropped add reports a hit")
  `RUPHT_ASSERT_NOW(a_miss_index_zero, out_miss, hit_rect_o == '0, "miss with nonzero index")

endmodule

bind rect_union_point_hit_test_top rupht_checker u_rupht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .inside_res_o (inside_res_o),
  .hit_rect_o   (hit_rect_o)
);
